>>> design/sss_pkg.sv
// Shared types, constants and segment encoder for the seven segment display scanner.
`default_nettype none
package sss_pkg;

  localparam int unsigned MAX_DIGITS = 4;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUMBER_W   = 14;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned DCOUNT_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [NUMBER_W-1:0] NUMBER_MAX = 14'd9999;

  // Reciprocals for the decimal split: floor(n * M >> S) == n / D for n <= 9999
  localparam logic [14:0] RECIP_1000 = 15'd16778;
  localparam int unsigned SHIFT_1000 = 24;
  localparam logic [13:0] RECIP_100  = 14'd10486;
  localparam int unsigned SHIFT_100  = 20;
  localparam logic [13:0] RECIP_10   = 14'd13108;
  localparam int unsigned SHIFT_10   = 17;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIGIT_COUNT   = 2'd0,
    CFG_SEGMENT_MODE  = 2'd1,
    CFG_SELECT_HIGH   = 2'd2,
    CFG_TICKS_PER_DIG = 2'd3
  } cfg_idx_t;

  typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic [DCOUNT_W-1:0] digit_count;
    logic                segment_mode;
    logic                select_active_high;
    logic [TICK_W-1:0]   ticks_per_digit;
  } cfg_t;

  // Bits 0..6 are segments a..g; codes above nine stay dark
  function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> design/sss_digit_split.sv
// Saturating binary to four-digit decimal split by reciprocal multiplication.
`default_nettype none
module sss_digit_split (
  input  wire logic [sss_pkg::NUMBER_W-1:0] number,
  output sss_pkg::digits_t                  digits
);

  logic [sss_pkg::NUMBER_W-1:0] sat;
  logic [28:0] p1000;
  logic [27:0] p100;
  logic [27:0] p10;
  logic [3:0]  q1000;
  logic [6:0]  q100;
  logic [9:0]  q10;
  logic [6:0]  r2;
  logic [9:0]  r1;
  logic [13:0] r0;

  assign sat = (number > sss_pkg::NUMBER_MAX) ? sss_pkg::NUMBER_MAX : number;

  // Three independent quotients, then strip the higher part with times-ten
  assign p1000 = 29'(sat) * 29'(sss_pkg::RECIP_1000);
  assign p100  = 28'(sat) * 28'(sss_pkg::RECIP_100);
  assign p10   = 28'(sat) * 28'(sss_pkg::RECIP_10);

  assign q1000 = p1000[sss_pkg::SHIFT_1000 +: 4];
  assign q100  = p100[sss_pkg::SHIFT_100 +: 7];
  assign q10   = p10[sss_pkg::SHIFT_10 +: 10];

  assign r2 = q100 - ({3'b0, q1000} << 3) - ({3'b0, q1000} << 1);
  assign r1 = q10 - ({3'b0, q100} << 3) - ({3'b0, q100} << 1);
  assign r0 = sat - ({4'b0, q10} << 3) - ({4'b0, q10} << 1);

  assign digits[3] = q1000;
  assign digits[2] = r2[3:0];
  assign digits[1] = r1[3:0];
  assign digits[0] = r0[3:0];

endmodule
`default_nettype wire

>>> design/sss_scan.sv
// Digit store, tick counter and scan state; holds the line levels shown as the result.
`default_nettype none
module sss_scan #(
  parameter int unsigned MAX_DIGITS = sss_pkg::MAX_DIGITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        advance,
  input  wire sss_pkg::cmd_t               cmd,
  input  wire sss_pkg::digits_t            new_digits,
  input  wire sss_pkg::cfg_t               cfg,
  output logic [sss_pkg::MAX_DIGITS-1:0]   digit_lines,
  output logic [sss_pkg::SEG_W-1:0]        segment_lines,
  output logic                             refreshed
);

  sss_pkg::digits_t                store_r, store_nxt;
  logic [1:0]                      pos_r, pos_nxt;
  logic [1:0]                      prev_r, prev_nxt;
  logic [sss_pkg::TICK_W-1:0]      tick_r, tick_nxt;
  logic [sss_pkg::MAX_DIGITS-1:0]  lines_r, lines_nxt;
  logic [sss_pkg::SEG_W-1:0]       seg_r, seg_nxt;
  logic                            refr_r, refr_nxt;

  logic [sss_pkg::TICK_W-1:0]      tick_inc;
  logic [sss_pkg::DIGIT_W-1:0]     cur_digit;
  logic                            show;
  logic [2:0]                      next_pos;

  assign tick_inc  = (tick_r == '1) ? tick_r : tick_r + 1'b1;
  assign cur_digit = store_r[pos_r];
  assign next_pos  = {1'b0, pos_r} + 3'd1;

  // Leading-zero blanking: units always lit
  always_comb begin
    case (pos_r)
      2'd0:    show = 1'b1;
      2'd1:    show = |{store_r[3], store_r[2], store_r[1]};
      2'd2:    show = |{store_r[3], store_r[2]};
      default: show = |store_r[3];
    endcase
  end

  always_comb begin
    store_nxt = store_r;
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    tick_nxt  = tick_r;
    lines_nxt = lines_r;
    seg_nxt   = seg_r;
    refr_nxt  = 1'b0;
    if (cmd == sss_pkg::CMD_SET) begin
      store_nxt = new_digits;
    end else if (tick_inc >= cfg.ticks_per_digit) begin
      tick_nxt           = '0;
      refr_nxt           = 1'b1;
      lines_nxt[prev_r]  = ~cfg.select_active_high;
      if (show) begin
        lines_nxt[pos_r] = cfg.select_active_high;
      end
      seg_nxt  = cfg.segment_mode ? sss_pkg::seg_encode(cur_digit)
                                  : {3'b0, cur_digit};
      prev_nxt = pos_r;
      if (next_pos == cfg.digit_count || next_pos >= 3'(MAX_DIGITS)) begin
        pos_nxt = 2'd0;
      end else begin
        pos_nxt = next_pos[1:0];
      end
    end else begin
      tick_nxt = tick_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      pos_r   <= '0;
      prev_r  <= '0;
      tick_r  <= '0;
      lines_r <= '0;
      seg_r   <= '0;
      refr_r  <= 1'b0;
    end else if (advance) begin
      store_r <= store_nxt;
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      tick_r  <= tick_nxt;
      lines_r <= lines_nxt;
      seg_r   <= seg_nxt;
      refr_r  <= refr_nxt;
    end
  end

  assign digit_lines   = lines_r;
  assign segment_lines = seg_r;
  assign refreshed     = refr_r;

endmodule
`default_nettype wire

>>> design/seven_segment_display_scanner.sv
// Top level of the multiplexed seven segment display scanner.
//
//   port group | direction | handshake             | payload
//   in_*       | input     | in_valid / in_stall   | command, number
//   out_*      | output    | out_valid / out_stall | digit_lines, segment_lines, refreshed
//   cfg_*      | input     | cfg_valid / cfg_ready | index, data
//
// Each transferred item is taken by the input register, then the decimal split and scan
// update land in the result registers. One item per cycle is sustained while out_stall
// is low; the result registers hold the scan state, so a stalled result holds the input
// register, and in_stall rises once that is also full.
// Reset clears the digits, scan position, tick count and line levels at once;
// configuration is ready in every cycle.
`default_nettype none
module seven_segment_display_scanner #(
  parameter int unsigned MAX_DIGITS = sss_pkg::MAX_DIGITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_command,
  input  wire logic [sss_pkg::NUMBER_W-1:0]  in_number,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sss_pkg::MAX_DIGITS-1:0]     out_digit_lines,
  output logic [sss_pkg::SEG_W-1:0]          out_segment_lines,
  output logic                               out_refreshed,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sss_pkg::TICK_W-1:0]    cfg_data
);

  sss_pkg::cfg_t                 cfg_r;
  logic                          in_vld_r;
  sss_pkg::cmd_t                 cmd_r;
  logic [sss_pkg::NUMBER_W-1:0]  number_r;
  logic                          out_vld_r;
  logic                          advance;
  logic                          in_take;
  sss_pkg::digits_t              digits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.digit_count        <= 3'd4;
      cfg_r.segment_mode       <= 1'b1;
      cfg_r.select_active_high <= 1'b1;
      cfg_r.ticks_per_digit    <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sss_pkg::cfg_idx_t'(cfg_index))
        sss_pkg::CFG_DIGIT_COUNT:   cfg_r.digit_count <= cfg_data[sss_pkg::DCOUNT_W-1:0];
        sss_pkg::CFG_SEGMENT_MODE:  cfg_r.segment_mode <= cfg_data[0];
        sss_pkg::CFG_SELECT_HIGH:   cfg_r.select_active_high <= cfg_data[0];
        sss_pkg::CFG_TICKS_PER_DIG: cfg_r.ticks_per_digit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance when the input register holds an item and the result slot is empty or being taken
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r    <= sss_pkg::cmd_t'(in_command);
      number_r <= in_number;
    end
  end

  sss_digit_split u_split (
    .number (number_r),
    .digits (digits)
  );

  sss_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .cmd           (cmd_r),
    .new_digits    (digits),
    .cfg           (cfg_r),
    .digit_lines   (out_digit_lines),
    .segment_lines (out_segment_lines),
    .refreshed     (out_refreshed)
  );

  assign out_valid = out_vld_r;

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the seven segment display scanner: random and directed items.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 1600;

  // Segment patterns a..g for codes 0..15, code 0 at the right-hand end
  localparam logic [15:0][sss_pkg::SEG_W-1:0] SEG_PATTERN = {
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h6F, 7'h7F,
    7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  typedef struct packed {
    sss_pkg::cmd_t                command;
    logic [sss_pkg::NUMBER_W-1:0] number;
  } item_t;

  typedef struct packed {
    logic [sss_pkg::MAX_DIGITS-1:0] digit_lines;
    logic [sss_pkg::SEG_W-1:0]      segment_lines;
    logic                           refreshed;
  } lines_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_command = 1'b0;
  logic [sss_pkg::NUMBER_W-1:0]   in_number = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [sss_pkg::MAX_DIGITS-1:0] out_digit_lines;
  logic [sss_pkg::SEG_W-1:0]      out_segment_lines;
  logic                           out_refreshed;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sss_pkg::TICK_W-1:0]     cfg_data = '0;

  seven_segment_display_scanner i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digit_lines   (out_digit_lines),
    .out_segment_lines (out_segment_lines),
    .out_refreshed     (out_refreshed),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Display state as the testbench sees it
  logic [sss_pkg::DIGIT_W-1:0]    shown_digits [sss_pkg::MAX_DIGITS];
  logic [1:0]                     scan_pos;
  logic [1:0]                     prev_pos;
  logic [sss_pkg::TICK_W-1:0]     tick_cnt;
  logic [sss_pkg::MAX_DIGITS-1:0] line_levels;
  logic [sss_pkg::SEG_W-1:0]      seg_levels;
  logic [sss_pkg::DCOUNT_W-1:0]   num_positions;
  logic                           seven_seg_mode;
  logic                           select_high;
  logic [sss_pkg::TICK_W-1:0]     ticks_per_refresh;

  item_t       pending_items [$];
  lines_t      expected_lines [$];
  item_t       next_item;
  lines_t      got_lines;
  lines_t      want_lines;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          feed_idle = 1'b1;
  bit          drain_idle = 1'b1;
  int unsigned items_sent = 0;
  int unsigned sets_sent = 0;
  int unsigned results_seen = 0;
  int unsigned refreshes_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  function automatic void refresh_digit();
    logic [1:0] pos;
    logic       show;
    int         nxt;
    pos = scan_pos;
    line_levels[prev_pos] = ~select_high;
    seg_levels = seven_seg_mode ? SEG_PATTERN[shown_digits[pos]]
                                : sss_pkg::SEG_W'(shown_digits[pos]);
    // blank leading zeros; the units place is always lit
    case (pos)
      2'd0:    show = 1'b1;
      2'd1:    show = (shown_digits[3] | shown_digits[2] | shown_digits[1]) != '0;
      2'd2:    show = (shown_digits[3] | shown_digits[2]) != '0;
      default: show = shown_digits[3] != '0;
    endcase
    if (show) line_levels[pos] = select_high;
    prev_pos = pos;
    nxt = int'(pos) + 1;
    if (nxt == int'(num_positions) || nxt >= int'(sss_pkg::MAX_DIGITS)) nxt = 0;
    scan_pos = 2'(nxt);
  endfunction

  function automatic lines_t next_display(logic command,
                                          logic [sss_pkg::NUMBER_W-1:0] number);
    int unsigned clipped;
    logic        fired;
    fired = 1'b0;
    if (command == sss_pkg::CMD_SET) begin
      clipped = (number > 9999) ? 9999 : int'(number);
      shown_digits[3] = sss_pkg::DIGIT_W'(clipped / 1000);
      shown_digits[2] = sss_pkg::DIGIT_W'(clipped / 100 % 10);
      shown_digits[1] = sss_pkg::DIGIT_W'(clipped / 10 % 10);
      shown_digits[0] = sss_pkg::DIGIT_W'(clipped % 10);
    end else begin
      if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= ticks_per_refresh) begin
        tick_cnt = '0;
        refresh_digit();
        fired = 1'b1;
      end
    end
    return '{line_levels, seg_levels, fired};
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned random_number();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 16383);
      1:       return $urandom_range(0, 9);
      2:       return $urandom_range(10, 99);
      3:       return $urandom_range(100, 999);
      4:       return $urandom_range(1000, 9999);
      default: return $urandom_range(9990, 16383);
    endcase
  endfunction

  // Input driver: hold a stalled transfer, otherwise idle or offer the next item
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_lines.push_back(next_display(in_command, in_number));
      items_sent++;
      if (in_command == sss_pkg::CMD_SET) sets_sent++;
    end
    if (!in_valid || !in_stall) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() != 0 && feed_idle && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        in_gap <= gap_len() - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_command <= next_item.command;
        in_number <= next_item.number;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      got_lines = '{out_digit_lines, out_segment_lines, out_refreshed};
      results_seen++;
      if (out_refreshed) refreshes_seen++;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with none expected: digits %h segments %h refreshed %b",
                   got_lines.digit_lines, got_lines.segment_lines, got_lines.refreshed);
      end else begin
        want_lines = expected_lines.pop_front();
        if (got_lines !== want_lines) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: digits %h/%h segments %h/%h refreshed %b/%b (want/got)",
                     results_seen, want_lines.digit_lines, got_lines.digit_lines,
                     want_lines.segment_lines, got_lines.segment_lines,
                     want_lines.refreshed, got_lines.refreshed);
        end
      end
    end
    if (out_gap != 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else if (drain_idle && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      out_gap <= gap_len() - 1;
    end else begin
      out_stall <= hold_left != 0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[seven_segment_display_scanner] ERROR");
      $finish;
    end
  end

  task automatic write_reg(sss_pkg::cfg_idx_t idx, logic [sss_pkg::TICK_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sss_pkg::CFG_DIGIT_COUNT:  num_positions = data[sss_pkg::DCOUNT_W-1:0];
      sss_pkg::CFG_SEGMENT_MODE: seven_seg_mode = data[0];
      sss_pkg::CFG_SELECT_HIGH:  select_high = data[0];
      default:                   ticks_per_refresh = data;
    endcase
  endtask

  task automatic queue_item(sss_pkg::cmd_t command, int unsigned number);
    pending_items.push_back('{command, sss_pkg::NUMBER_W'(number)});
  endtask

  // Wait until every transfer has gone through and its result has come back
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_lines.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic pick_settings(bit write_all);
    int unsigned                r;
    logic [sss_pkg::TICK_W-1:0] ticks;
    if (write_all || $urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 11);
      if (r < 8) write_reg(sss_pkg::CFG_DIGIT_COUNT, sss_pkg::TICK_W'(r % 4 + 1));
      else if (r == 8) write_reg(sss_pkg::CFG_DIGIT_COUNT, '0);
      else write_reg(sss_pkg::CFG_DIGIT_COUNT, sss_pkg::TICK_W'(r - 4));
    end
    if (write_all || $urandom_range(0, 3) != 0)
      write_reg(sss_pkg::CFG_SEGMENT_MODE, sss_pkg::TICK_W'($urandom_range(0, 1)));
    if (write_all || $urandom_range(0, 3) != 0)
      write_reg(sss_pkg::CFG_SELECT_HIGH, sss_pkg::TICK_W'($urandom_range(0, 1)));
    if (write_all || $urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 19);
      if (r < 8) ticks = sss_pkg::TICK_W'(1);
      else if (r < 13) ticks = sss_pkg::TICK_W'($urandom_range(0, 3));
      else if (r < 18) ticks = sss_pkg::TICK_W'($urandom_range(2, 12));
      else if (r == 18) ticks = sss_pkg::TICK_W'($urandom_range(13, 200));
      else ticks = sss_pkg::TICK_W'($urandom_range(0, 65535));
      write_reg(sss_pkg::CFG_TICKS_PER_DIG, ticks);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_items;
    int unsigned random_total;
    foreach (shown_digits[i]) shown_digits[i] = '0;
    scan_pos = '0;
    prev_pos = '0;
    tick_cnt = '0;
    line_levels = '0;
    seg_levels = '0;
    num_positions = 3'd4;
    seven_seg_mode = 1'b1;
    select_high = 1'b1;
    ticks_per_refresh = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Settings after reset: four places, segments, active-high selects, every tick
    queue_item(sss_pkg::CMD_TICK, 16383);
    queue_item(sss_pkg::CMD_SET, 16383);
    repeat (4) queue_item(sss_pkg::CMD_TICK, 0);
    queue_item(sss_pkg::CMD_SET, 10000);
    queue_item(sss_pkg::CMD_SET, 0);
    repeat (2) queue_item(sss_pkg::CMD_TICK, 0);
    queue_item(sss_pkg::CMD_SET, 305);
    repeat (3) queue_item(sss_pkg::CMD_TICK, 0);
    settle();

    // BCD lines, active-low selects, one place, zero refresh interval
    write_reg(sss_pkg::CFG_TICKS_PER_DIG, '0);
    write_reg(sss_pkg::CFG_SELECT_HIGH, '0);
    write_reg(sss_pkg::CFG_SEGMENT_MODE, '0);
    write_reg(sss_pkg::CFG_DIGIT_COUNT, sss_pkg::TICK_W'(1));
    queue_item(sss_pkg::CMD_SET, 9999);
    repeat (3) queue_item(sss_pkg::CMD_TICK, 0);
    settle();

    // Slowest interval, then lower it below the count already reached
    write_reg(sss_pkg::CFG_TICKS_PER_DIG, '1);
    write_reg(sss_pkg::CFG_DIGIT_COUNT, sss_pkg::TICK_W'(7));
    write_reg(sss_pkg::CFG_SEGMENT_MODE, sss_pkg::TICK_W'(1));
    repeat (3) queue_item(sss_pkg::CMD_TICK, 0);
    settle();
    write_reg(sss_pkg::CFG_TICKS_PER_DIG, sss_pkg::TICK_W'(2));
    write_reg(sss_pkg::CFG_DIGIT_COUNT, '0);
    repeat (3) queue_item(sss_pkg::CMD_TICK, 0);
    settle();

    phase = 0;
    random_total = 0;
    while (random_total < RANDOM_ITEMS) begin
      pick_settings(phase == 0);
      // the third phase keeps the sender busy while the receiver holds off
      feed_idle = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      drain_idle = $urandom_range(0, 3) != 0;
      if (phase == 2) hold_req = 1'b1;
      phase_items = $urandom_range(60, 140);
      repeat (phase_items) begin
        if ($urandom_range(0, 4) == 0) queue_item(sss_pkg::CMD_SET, random_number());
        else queue_item(sss_pkg::CMD_TICK, $urandom_range(0, 16383));
      end
      random_total += phase_items;
      settle();
      phase++;
    end

    repeat (5) @(negedge clk);
    $display("Sent %0d items, %0d of them value updates, across %0d setting phases.",
             items_sent, sets_sent, phase + 4);
    $display("Checked %0d results including %0d digit refreshes; %0d mismatches.",
             results_seen, refreshes_seen, mismatches);
    if (mismatches == 0) begin
      $display("[seven_segment_display_scanner] OK");
    end else begin
      $display("[seven_segment_display_scanner] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sss_pkg.sv
design/sss_digit_split.sv
design/sss_scan.sv
design/seven_segment_display_scanner.sv
test/testbench.sv
